// ===== rtl/core/pixel_shape_coverage_test_core_assert.svh =====
// Assertion macros for the pixel shape coverage core.
// Included by the top level; no other dependencies.
`ifndef PIXEL_SHAPE_COVERAGE_TEST_CORE_ASSERT_SVH
`define PIXEL_SHAPE_COVERAGE_TEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define PSC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("psc assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("psc assertion failed");
`else
`define PSC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/psc_pkg.sv =====
// Shared types and operand tables for the pixel shape coverage pipeline.
// No dependencies.
`timescale 1ns / 1ps

package psc_pkg;

    // Shape kind codes
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RECT = 2'd1,
        KIND_TRI  = 2'd2,
        KIND_CIRC = 2'd3
    } kind_t;

    // Coordinate difference slots (first stage)
    localparam int DIFF_BAX = 0;   // bx - ax
    localparam int DIFF_BAY = 1;   // by - ay
    localparam int DIFF_CAX = 2;   // cx - ax
    localparam int DIFF_CAY = 3;   // cy - ay
    localparam int DIFF_CBX = 4;   // cx - bx
    localparam int DIFF_CBY = 5;   // cy - by
    localparam int DIFF_ACX = 6;   // ax - cx
    localparam int DIFF_ACY = 7;   // ay - cy
    localparam int DIFF_PAX = 8;   // px - ax
    localparam int DIFF_PAY = 9;   // py - ay
    localparam int DIFF_PBX = 10;  // px - bx
    localparam int DIFF_PBY = 11;  // py - by
    localparam int DIFF_PCX = 12;  // px - cx
    localparam int DIFF_PCY = 13;  // py - cy
    localparam int DIFF_RAD = 14;  // radius, zero extended
    localparam int NUM_DIFF = 15;

    // Product slots (second stage)
    localparam int PROD_AREA_A = 0;
    localparam int PROD_AREA_B = 1;
    localparam int PROD_E0_A   = 2;
    localparam int PROD_E0_B   = 3;
    localparam int PROD_E1_A   = 4;
    localparam int PROD_E1_B   = 5;
    localparam int PROD_E2_A   = 6;
    localparam int PROD_E2_B   = 7;
    localparam int PROD_DX2    = 8;
    localparam int PROD_DY2    = 9;
    localparam int PROD_R2     = 10;
    localparam int NUM_PROD    = 11;

    // Operand pairs for each product slot
    localparam int PROD_OP_A [NUM_PROD] = '{
        DIFF_BAX, DIFF_BAY, DIFF_BAX, DIFF_BAY, DIFF_CBX, DIFF_CBY,
        DIFF_ACX, DIFF_ACY, DIFF_PAX, DIFF_PAY, DIFF_RAD
    };
    localparam int PROD_OP_B [NUM_PROD] = '{
        DIFF_CAY, DIFF_CAX, DIFF_PAY, DIFF_PAX, DIFF_PBY, DIFF_PBX,
        DIFF_PCY, DIFF_PCX, DIFF_PAX, DIFF_PAY, DIFF_RAD
    };

    // Sum slots (third stage)
    localparam int SUM_AREA = 0;
    localparam int SUM_E0   = 1;
    localparam int SUM_E1   = 2;
    localparam int SUM_E2   = 3;
    localparam int SUM_DIST = 4;
    localparam int SUM_R2   = 5;
    localparam int NUM_SUM  = 6;

endpackage

// ===== rtl/core/psc_diff.sv =====
// Stage 1: coordinate differences and the rectangle bound test.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_diff #(
    parameter int COORD_BITS = 9
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  psc_pkg::kind_t               in_kind,
    input  logic [COORD_BITS-1:0]        ax,
    input  logic [COORD_BITS-1:0]        ay,
    input  logic [COORD_BITS-1:0]        bx,
    input  logic [COORD_BITS-1:0]        by,
    input  logic [COORD_BITS-1:0]        cx,
    input  logic [COORD_BITS-1:0]        cy,
    input  logic [COORD_BITS-1:0]        px,
    input  logic [COORD_BITS-1:0]        py,
    output logic                         out_valid,
    input  logic                         out_ready,
    output psc_pkg::kind_t               out_kind,
    output logic                         out_rect_in,
    output logic signed [COORD_BITS:0]   out_diff [psc_pkg::NUM_DIFF]
);

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0] ax_s, ay_s, bx_s, by_s, cx_s, cy_s, px_s, py_s;
    logic signed [DW-1:0] diff_next [psc_pkg::NUM_DIFF];
    logic signed [DW-1:0] diff_reg  [psc_pkg::NUM_DIFF];
    logic                 rect_next, rect_reg;
    psc_pkg::kind_t       kind_reg;
    logic                 valid_reg;

    // Zero-extend into signed form
    assign ax_s = $signed({1'b0, ax});
    assign ay_s = $signed({1'b0, ay});
    assign bx_s = $signed({1'b0, bx});
    assign by_s = $signed({1'b0, by});
    assign cx_s = $signed({1'b0, cx});
    assign cy_s = $signed({1'b0, cy});
    assign px_s = $signed({1'b0, px});
    assign py_s = $signed({1'b0, py});

    // Differences feeding the edge functions and the circle test
    always_comb begin
        diff_next[psc_pkg::DIFF_BAX] = bx_s - ax_s;
        diff_next[psc_pkg::DIFF_BAY] = by_s - ay_s;
        diff_next[psc_pkg::DIFF_CAX] = cx_s - ax_s;
        diff_next[psc_pkg::DIFF_CAY] = cy_s - ay_s;
        diff_next[psc_pkg::DIFF_CBX] = cx_s - bx_s;
        diff_next[psc_pkg::DIFF_CBY] = cy_s - by_s;
        diff_next[psc_pkg::DIFF_ACX] = ax_s - cx_s;
        diff_next[psc_pkg::DIFF_ACY] = ay_s - cy_s;
        diff_next[psc_pkg::DIFF_PAX] = px_s - ax_s;
        diff_next[psc_pkg::DIFF_PAY] = py_s - ay_s;
        diff_next[psc_pkg::DIFF_PBX] = px_s - bx_s;
        diff_next[psc_pkg::DIFF_PBY] = py_s - by_s;
        diff_next[psc_pkg::DIFF_PCX] = px_s - cx_s;
        diff_next[psc_pkg::DIFF_PCY] = py_s - cy_s;
        diff_next[psc_pkg::DIFF_RAD] = cx_s;
    end

    // Inclusive rectangle bounds; an inverted rectangle fails here
    assign rect_next = (px >= ax) && (px <= bx) && (py >= ay) && (py <= by);

    assign in_ready = !valid_reg || out_ready;

    // Stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            kind_reg <= in_kind;
            rect_reg <= rect_next;
            diff_reg <= diff_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_rect_in = rect_reg;
    assign out_diff    = diff_reg;

endmodule

// ===== rtl/core/psc_mul.sv =====
// Stage 2: bank of signed multipliers for edge terms and squared distances.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_mul #(
    parameter int COORD_BITS = 9
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  psc_pkg::kind_t                   in_kind,
    input  logic                             in_rect_in,
    input  logic signed [COORD_BITS:0]       in_diff [psc_pkg::NUM_DIFF],
    output logic                             out_valid,
    input  logic                             out_ready,
    output psc_pkg::kind_t                   out_kind,
    output logic                             out_rect_in,
    output logic signed [2*COORD_BITS+1:0]   out_prod [psc_pkg::NUM_PROD]
);

    localparam int PW = 2 * COORD_BITS + 2;

    logic signed [PW-1:0] prod_next [psc_pkg::NUM_PROD];
    logic signed [PW-1:0] prod_reg  [psc_pkg::NUM_PROD];
    psc_pkg::kind_t       kind_reg;
    logic                 rect_reg;
    logic                 valid_reg;

    // One multiplier per product slot, operands from the package table
    for (genvar i = 0; i < psc_pkg::NUM_PROD; i++) begin : g_mul
        assign prod_next[i] = PW'(in_diff[psc_pkg::PROD_OP_A[i]])
                            * PW'(in_diff[psc_pkg::PROD_OP_B[i]]);
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            kind_reg <= in_kind;
            rect_reg <= in_rect_in;
            prod_reg <= prod_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_rect_in = rect_reg;
    assign out_prod    = prod_reg;

endmodule

// ===== rtl/core/psc_sum.sv =====
// Stage 3: edge functions, doubled area and squared distance from products.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_sum #(
    parameter int COORD_BITS = 9
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  psc_pkg::kind_t                   in_kind,
    input  logic                             in_rect_in,
    input  logic signed [2*COORD_BITS+1:0]   in_prod [psc_pkg::NUM_PROD],
    output logic                             out_valid,
    input  logic                             out_ready,
    output psc_pkg::kind_t                   out_kind,
    output logic                             out_rect_in,
    output logic signed [2*COORD_BITS+2:0]   out_sum [psc_pkg::NUM_SUM]
);

    localparam int SW = 2 * COORD_BITS + 3;

    logic signed [SW-1:0] sum_next [psc_pkg::NUM_SUM];
    logic signed [SW-1:0] sum_reg  [psc_pkg::NUM_SUM];
    psc_pkg::kind_t       kind_reg;
    logic                 rect_reg;
    logic                 valid_reg;

    // Cross-product differences and the distance sum
    always_comb begin
        sum_next[psc_pkg::SUM_AREA] = SW'(in_prod[psc_pkg::PROD_AREA_A])
                                    - SW'(in_prod[psc_pkg::PROD_AREA_B]);
        sum_next[psc_pkg::SUM_E0]   = SW'(in_prod[psc_pkg::PROD_E0_A])
                                    - SW'(in_prod[psc_pkg::PROD_E0_B]);
        sum_next[psc_pkg::SUM_E1]   = SW'(in_prod[psc_pkg::PROD_E1_A])
                                    - SW'(in_prod[psc_pkg::PROD_E1_B]);
        sum_next[psc_pkg::SUM_E2]   = SW'(in_prod[psc_pkg::PROD_E2_A])
                                    - SW'(in_prod[psc_pkg::PROD_E2_B]);
        sum_next[psc_pkg::SUM_DIST] = SW'(in_prod[psc_pkg::PROD_DX2])
                                    + SW'(in_prod[psc_pkg::PROD_DY2]);
        sum_next[psc_pkg::SUM_R2]   = SW'(in_prod[psc_pkg::PROD_R2]);
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            kind_reg <= in_kind;
            rect_reg <= in_rect_in;
            sum_reg  <= sum_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_rect_in = rect_reg;
    assign out_sum     = sum_reg;

endmodule

// ===== rtl/core/psc_decide.sv =====
// Stage 4: sign tests, per-kind coverage select and the output register.
// Depends on psc_pkg.
`timescale 1ns / 1ps

module psc_decide #(
    parameter int COORD_BITS = 9
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  psc_pkg::kind_t                   in_kind,
    input  logic                             in_rect_in,
    input  logic signed [2*COORD_BITS+2:0]   in_sum [psc_pkg::NUM_SUM],
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_covered,
    output logic                             out_bad_kind
);

    logic area_pos, area_neg;
    logic all_nonneg, all_nonpos;
    logic tri_in, circ_in;
    logic covered_next, bad_next;
    logic covered_reg, bad_reg;
    logic valid_reg;

    // Edge sign tests; inclusive on edges and vertices
    always_comb begin
        area_pos   = (in_sum[psc_pkg::SUM_AREA] > 0);
        area_neg   = (in_sum[psc_pkg::SUM_AREA] < 0);
        all_nonneg = (in_sum[psc_pkg::SUM_E0] >= 0) && (in_sum[psc_pkg::SUM_E1] >= 0)
                  && (in_sum[psc_pkg::SUM_E2] >= 0);
        all_nonpos = (in_sum[psc_pkg::SUM_E0] <= 0) && (in_sum[psc_pkg::SUM_E1] <= 0)
                  && (in_sum[psc_pkg::SUM_E2] <= 0);
        // zero-area triangle covers nothing
        tri_in     = (area_pos && all_nonneg) || (area_neg && all_nonpos);
        circ_in    = (in_sum[psc_pkg::SUM_DIST] <= in_sum[psc_pkg::SUM_R2]);
    end

    // Select by shape kind
    always_comb begin
        covered_next = 1'b0;
        bad_next     = 1'b0;
        case (in_kind)
            psc_pkg::KIND_RECT: begin
                covered_next = in_rect_in;
            end
            psc_pkg::KIND_TRI: begin
                covered_next = tri_in;
            end
            psc_pkg::KIND_CIRC: begin
                covered_next = circ_in;
            end
            default: begin
                bad_next = 1'b1;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            covered_reg <= covered_next;
            bad_reg     <= bad_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_covered  = covered_reg;
    assign out_bad_kind = bad_reg;

endmodule

// ===== rtl/core/pixel_shape_coverage_test_core.sv =====
// Pixel coverage test for rectangle, triangle and circle shapes.
// Registered stages from input transaction to result: diff, multiply, sum, decide.
// Throughput: one transaction per cycle; each stage holds while the next is full.
// Reset (aresetn, synchronous, active low) clears the stage valid bits only.
// Depends on psc_pkg, psc_diff, psc_mul, psc_sum, psc_decide and the assert header.
`timescale 1ns / 1ps
`include "pixel_shape_coverage_test_core_assert.svh"

module pixel_shape_coverage_test_core #(
    parameter int COORD_BITS = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_shape_kind,
    input  logic [COORD_BITS-1:0] s_first_x,
    input  logic [COORD_BITS-1:0] s_first_y,
    input  logic [COORD_BITS-1:0] s_second_x,
    input  logic [COORD_BITS-1:0] s_second_y,
    input  logic [COORD_BITS-1:0] s_third_x,
    input  logic [COORD_BITS-1:0] s_third_y,
    input  logic [COORD_BITS-1:0] s_pixel_x,
    input  logic [COORD_BITS-1:0] s_pixel_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_covered,
    output logic                  m_bad_kind
);

    // Stage 1 -> 2
    logic                           d_valid, d_ready, d_rect_in;
    psc_pkg::kind_t                 d_kind;
    logic signed [COORD_BITS:0]     d_diff [psc_pkg::NUM_DIFF];
    // Stage 2 -> 3
    logic                           p_valid, p_ready, p_rect_in;
    psc_pkg::kind_t                 p_kind;
    logic signed [2*COORD_BITS+1:0] p_prod [psc_pkg::NUM_PROD];
    // Stage 3 -> 4
    logic                           u_valid, u_ready, u_rect_in;
    psc_pkg::kind_t                 u_kind;
    logic signed [2*COORD_BITS+2:0] u_sum [psc_pkg::NUM_SUM];

    psc_diff #(.COORD_BITS(COORD_BITS)) u_diff (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_kind     (psc_pkg::kind_t'(s_shape_kind)),
        .ax          (s_first_x),
        .ay          (s_first_y),
        .bx          (s_second_x),
        .by          (s_second_y),
        .cx          (s_third_x),
        .cy          (s_third_y),
        .px          (s_pixel_x),
        .py          (s_pixel_y),
        .out_valid   (d_valid),
        .out_ready   (d_ready),
        .out_kind    (d_kind),
        .out_rect_in (d_rect_in),
        .out_diff    (d_diff)
    );

    psc_mul #(.COORD_BITS(COORD_BITS)) u_mul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (d_valid),
        .in_ready    (d_ready),
        .in_kind     (d_kind),
        .in_rect_in  (d_rect_in),
        .in_diff     (d_diff),
        .out_valid   (p_valid),
        .out_ready   (p_ready),
        .out_kind    (p_kind),
        .out_rect_in (p_rect_in),
        .out_prod    (p_prod)
    );

    psc_sum #(.COORD_BITS(COORD_BITS)) u_sum_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (p_valid),
        .in_ready    (p_ready),
        .in_kind     (p_kind),
        .in_rect_in  (p_rect_in),
        .in_prod     (p_prod),
        .out_valid   (u_valid),
        .out_ready   (u_ready),
        .out_kind    (u_kind),
        .out_rect_in (u_rect_in),
        .out_sum     (u_sum)
    );

    psc_decide #(.COORD_BITS(COORD_BITS)) u_decide (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (u_valid),
        .in_ready     (u_ready),
        .in_kind      (u_kind),
        .in_rect_in   (u_rect_in),
        .in_sum       (u_sum),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_covered  (m_covered),
        .out_bad_kind (m_bad_kind)
    );

    // An unknown kind never reports coverage
    `PSC_ASSERT_IMPLY(a_bad_not_covered, aclk, aresetn, m_valid, !(m_covered && m_bad_kind))
    // With the output slot free or draining, the whole pipe accepts
    `PSC_ASSERT_IMPLY(a_free_accepts, aclk, aresetn, (!m_valid || m_ready), s_ready)
    // An unknown kind leaving stage 3 shows up flagged at the output
    `PSC_ASSERT_NEXT(a_bad_kind_flag, aclk, aresetn, (u_valid && u_ready && (u_kind == psc_pkg::KIND_NONE)), (m_valid && m_bad_kind))

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for pixel_shape_coverage_test_core: directed shape cases, then
// random traffic under three idle patterns and an output hold-off. Depends on psc_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int COORD_BITS      = 9;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef logic [COORD_BITS-1:0] coord_t;

    // One coverage query: shape description plus pixel
    typedef struct {
        psc_pkg::kind_t kind;
        coord_t         ax;
        coord_t         ay;
        coord_t         bx;
        coord_t         by;
        coord_t         cx;
        coord_t         cy;
        coord_t         px;
        coord_t         py;
    } shape_query_t;

    typedef struct {
        logic covered;
        logic bad_kind;
    } coverage_t;

    logic       aclk;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [1:0] s_shape_kind = 2'd0;
    coord_t     s_first_x    = '0;
    coord_t     s_first_y    = '0;
    coord_t     s_second_x   = '0;
    coord_t     s_second_y   = '0;
    coord_t     s_third_x    = '0;
    coord_t     s_third_y    = '0;
    coord_t     s_pixel_x    = '0;
    coord_t     s_pixel_y    = '0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic       m_covered;
    logic       m_bad_kind;

    coverage_t  coverage_q[$];
    int         mismatch_count   = 0;
    int         tx_idle_pct      = 0;
    int         rx_idle_pct      = 0;
    bit         hold_off_request = 1'b0;

    pixel_shape_coverage_test_core #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_shape_kind(s_shape_kind),
        .s_first_x   (s_first_x),
        .s_first_y   (s_first_y),
        .s_second_x  (s_second_x),
        .s_second_y  (s_second_y),
        .s_third_x   (s_third_x),
        .s_third_y   (s_third_y),
        .s_pixel_x   (s_pixel_x),
        .s_pixel_y   (s_pixel_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_covered   (m_covered),
        .m_bad_kind  (m_bad_kind)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Doubled signed area of (a, b, p); positive when p is left of a->b
    function automatic longint edge_value(longint ax, longint ay, longint bx, longint by,
                                          longint px, longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    // Coverage predictor, exact integer arithmetic
    function automatic coverage_t predict_coverage(shape_query_t q);
        coverage_t res;
        longint    ax, ay, bx, by, cx, cy, px, py;
        longint    area, e0, e1, e2, dx, dy;
        ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
        cx = q.cx; cy = q.cy; px = q.px; py = q.py;
        res.covered  = 1'b0;
        res.bad_kind = 1'b0;
        case (q.kind)
            psc_pkg::KIND_RECT: begin
                res.covered = (px >= ax) && (px <= bx) && (py >= ay) && (py <= by);
            end
            psc_pkg::KIND_TRI: begin
                area = edge_value(ax, ay, bx, by, cx, cy);
                e0   = edge_value(ax, ay, bx, by, px, py);
                e1   = edge_value(bx, by, cx, cy, px, py);
                e2   = edge_value(cx, cy, ax, ay, px, py);
                if (area > 0)
                    res.covered = (e0 >= 0) && (e1 >= 0) && (e2 >= 0);
                else if (area < 0)
                    res.covered = (e0 <= 0) && (e1 <= 0) && (e2 <= 0);
            end
            psc_pkg::KIND_CIRC: begin
                dx = px - ax;
                dy = py - ay;
                res.covered = (dx * dx + dy * dy) <= (cx * cx);
            end
            default: begin
                res.bad_kind = 1'b1;
            end
        endcase
        return res;
    endfunction

    // Offer one transaction; the expectation is queued at the accepting edge
    task automatic send_query(shape_query_t q);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_shape_kind <= q.kind;
        s_first_x    <= q.ax;
        s_first_y    <= q.ay;
        s_second_x   <= q.bx;
        s_second_y   <= q.by;
        s_third_x    <= q.cx;
        s_third_y    <= q.cy;
        s_pixel_x    <= q.px;
        s_pixel_y    <= q.py;
        do @(posedge aclk); while (!s_ready);
        coverage_q.push_back(predict_coverage(q));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (coverage_q.size() != 0);
    endtask

    // Result checker
    always @(posedge aclk) begin : check_result
        coverage_t expected;
        if (aresetn && m_valid && m_ready) begin
            if (coverage_q.size() == 0) begin
                $display("%0t: unexpected result: covered=%0b bad_kind=%0b",
                         $time, m_covered, m_bad_kind);
                mismatch_count++;
            end else begin
                expected = coverage_q.pop_front();
                if (m_covered !== expected.covered) begin
                    $display("%0t: covered mismatch: expected %0b, actual %0b",
                             $time, expected.covered, m_covered);
                    mismatch_count++;
                end
                if (m_bad_kind !== expected.bad_kind) begin
                    $display("%0t: bad_kind mismatch: expected %0b, actual %0b",
                             $time, expected.bad_kind, m_bad_kind);
                    mismatch_count++;
                end
            end
        end
    end

    // Result-side ready: random stalls, or a long hold-off on request
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall_left       = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Value near c, clamped to the coordinate range
    function automatic coord_t near_coord(coord_t c, int spread);
        int v;
        v = int'(c) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(COORD_MAX));
    endfunction

    // Random query: mostly shapes with the pixel placed near their boundary
    function automatic shape_query_t make_random_query();
        shape_query_t q;
        coord_t       tmp;
        int           style;
        int           radius;
        style = $urandom_range(99);
        q.kind = psc_pkg::kind_t'($urandom_range(3));
        q.ax = rand_coord(); q.ay = rand_coord();
        q.bx = rand_coord(); q.by = rand_coord();
        q.cx = rand_coord(); q.cy = rand_coord();
        q.px = rand_coord(); q.py = rand_coord();
        if (style < 15)
            return q;   // pure noise, any kind
        q.kind = psc_pkg::kind_t'($urandom_range(3, 1));
        case (q.kind)
            psc_pkg::KIND_RECT: begin
                // mostly well-ordered bounds
                if (style < 85 && q.ax > q.bx) begin
                    tmp = q.ax; q.ax = q.bx; q.bx = tmp;
                end
                if (style < 85 && q.ay > q.by) begin
                    tmp = q.ay; q.ay = q.by; q.by = tmp;
                end
                q.px = near_coord($urandom_range(1) ? q.ax : q.bx, 3);
                q.py = near_coord($urandom_range(1) ? q.ay : q.by, 3);
                if ($urandom_range(1))
                    q.px = coord_t'($urandom_range(q.bx, q.ax));
            end
            psc_pkg::KIND_TRI: begin
                if (style < 60) begin
                    q.bx = near_coord(q.ax, 40); q.by = near_coord(q.ay, 40);
                    q.cx = near_coord(q.ax, 40); q.cy = near_coord(q.ay, 40);
                end
                case ($urandom_range(2))
                    0: begin
                        q.px = near_coord(q.ax, 4); q.py = near_coord(q.ay, 4);
                    end
                    1: begin
                        q.px = coord_t'((int'(q.ax) + int'(q.bx) + int'(q.cx)) / 3);
                        q.py = coord_t'((int'(q.ay) + int'(q.by) + int'(q.cy)) / 3);
                        q.px = near_coord(q.px, 20); q.py = near_coord(q.py, 20);
                    end
                    default: begin
                        q.px = coord_t'((int'(q.ax) + int'(q.bx)) / 2);
                        q.py = coord_t'((int'(q.ay) + int'(q.by)) / 2);
                        q.px = near_coord(q.px, 2); q.py = near_coord(q.py, 2);
                    end
                endcase
            end
            default: begin
                // circle: radius often small, pixel around the rim
                if (style < 70)
                    q.cx = coord_t'($urandom_range(63));
                radius = int'(q.cx);
                q.px = near_coord(q.ax, radius + 2);
                q.py = near_coord(q.ay, radius + 2);
            end
        endcase
        return q;
    endfunction

    task automatic test_unknown_kind();
        send_query('{psc_pkg::KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0});
        send_query('{psc_pkg::KIND_NONE, 511, 511, 511, 511, 511, 511, 511, 511});
    endtask

    // Rectangle: inclusive bounds, just outside, inverted, full screen
    task automatic test_rectangle();
        send_query('{psc_pkg::KIND_RECT, 10, 20, 100, 200, 511, 511, 10, 20});
        send_query('{psc_pkg::KIND_RECT, 10, 20, 100, 200, 0, 0, 100, 200});
        send_query('{psc_pkg::KIND_RECT, 10, 20, 100, 200, 0, 0, 101, 50});
        send_query('{psc_pkg::KIND_RECT, 10, 20, 100, 200, 0, 0, 50, 19});
        send_query('{psc_pkg::KIND_RECT, 100, 20, 10, 200, 0, 0, 50, 50});
        send_query('{psc_pkg::KIND_RECT, 0, 0, 511, 511, 0, 0, 511, 0});
    endtask

    // Triangle: both windings, edge, vertex, degenerate, large
    task automatic test_triangle();
        send_query('{psc_pkg::KIND_TRI, 10, 10, 100, 10, 10, 100, 30, 30});
        send_query('{psc_pkg::KIND_TRI, 10, 10, 10, 100, 100, 10, 30, 30});
        send_query('{psc_pkg::KIND_TRI, 10, 10, 100, 10, 10, 100, 55, 55});
        send_query('{psc_pkg::KIND_TRI, 10, 10, 100, 10, 10, 100, 56, 55});
        send_query('{psc_pkg::KIND_TRI, 10, 10, 100, 10, 10, 100, 100, 10});
        send_query('{psc_pkg::KIND_TRI, 0, 0, 100, 100, 200, 200, 50, 50});
        send_query('{psc_pkg::KIND_TRI, 7, 7, 7, 7, 7, 7, 7, 7});
        send_query('{psc_pkg::KIND_TRI, 0, 0, 511, 0, 0, 511, 511, 511});
    endtask

    // Circle: zero radius, rim, extreme radius
    task automatic test_circle();
        send_query('{psc_pkg::KIND_CIRC, 200, 300, 511, 511, 0, 511, 200, 300});
        send_query('{psc_pkg::KIND_CIRC, 200, 300, 0, 0, 0, 511, 201, 300});
        send_query('{psc_pkg::KIND_CIRC, 100, 100, 0, 0, 5, 511, 103, 104});
        send_query('{psc_pkg::KIND_CIRC, 100, 100, 0, 0, 5, 511, 104, 104});
        send_query('{psc_pkg::KIND_CIRC, 0, 0, 0, 0, 511, 0, 511, 511});
        send_query('{psc_pkg::KIND_CIRC, 511, 511, 0, 0, 511, 0, 0, 511});
    endtask

    task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_query(make_random_query());
        wait_for_drain();
    endtask

    // Long result hold-off while the input keeps offering, so the pipe backs up
    task automatic test_output_hold_off();
        tx_idle_pct      = 0;
        rx_idle_pct      = 0;
        hold_off_request = 1'b1;
        repeat (40) send_query(make_random_query());
        wait_for_drain();
    endtask

    initial begin : main
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 32;
        rx_idle_pct = 78;
        test_unknown_kind();
        test_rectangle();
        test_triangle();
        test_circle();
        wait_for_drain();

        test_random_traffic(420, 32, 78);
        test_random_traffic(420, 78, 32);
        test_output_hold_off();
        test_random_traffic(420, 0, 0);

        repeat (10) @(posedge aclk);
        if (coverage_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, coverage_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
